[rtl/core/cbh_pkg.sv]
// ---------------------------------------------------------------------------
// cbh_pkg
// Shared constants, types and helper functions for the character bigram
// histogram: symbol decode, pair addressing and controller/datapath links.
// ---------------------------------------------------------------------------
package cbh_pkg;

	// Counter and table geometry
	localparam int COUNT_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int EXT_WIDTH   = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;
	localparam int SYM_WIDTH   = 6;
	localparam int NUM_SYMBOLS = 36;
	localparam int NUM_PAIRS   = NUM_SYMBOLS * NUM_SYMBOLS;
	localparam int ADDR_WIDTH  = $clog2(NUM_PAIRS);

	// Configuration port
	localparam int CFG_ADDR_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 32;
	localparam logic [CFG_DATA_WIDTH-1:0] THRESHOLD_RESET = 32'd200000;
	localparam logic REG_THRESHOLD = 1'b0;   // register index, paddr[2]

	// Item opcodes
	localparam logic OP_TEXT  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Controller -> datapath commands
	typedef struct packed {
		logic clr_step;   // zero one table entry of the clearing pass
		logic accept;     // take the input item, launch the table read
		logic update;     // finish the item: write back and/or load result
	} cbh_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic clr_last;   // clearing pass is at its final entry
		logic is_query;   // item in flight is a query
		logic out_free;   // result register can take a new result
	} cbh_stat_t;

	typedef struct packed {
		logic                 valid;
		logic [SYM_WIDTH-1:0] sym;
	} cbh_sym_t;

	// Map a raw byte to a symbol: digits 0-9, letters (either case) 10-35
	function automatic cbh_sym_t sym_decode(input logic [7:0] b);
		cbh_sym_t r;
		logic [7:0] t;
		r = '0;
		t = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			t       = b - 8'h30;
			r.valid = 1'b1;
		end else if (b >= 8'h61 && b <= 8'h7A) begin
			t       = b - 8'h57;
			r.valid = 1'b1;
		end else if (b >= 8'h41 && b <= 8'h5A) begin
			t       = b - 8'h37;
			r.valid = 1'b1;
		end
		r.sym = t[SYM_WIDTH-1:0];
		return r;
	endfunction

	// Table address first*36 + second, built from shifts
	function automatic logic [ADDR_WIDTH-1:0] pair_addr(input logic [SYM_WIDTH-1:0] a,
	                                                    input logic [SYM_WIDTH-1:0] b);
		return ADDR_WIDTH'({a, 5'b0}) + ADDR_WIDTH'({a, 2'b0}) + ADDR_WIDTH'(b);
	endfunction

endpackage

[rtl/core/cbh_if.sv]
// ---------------------------------------------------------------------------
// cbh_if
// Valid/ready channel interfaces for histogram items and query results.
// ---------------------------------------------------------------------------
interface cbh_in_if import cbh_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [7:0]           text_byte;
	logic [SYM_WIDTH-1:0] query_first;
	logic [SYM_WIDTH-1:0] query_second;
	logic                 clear_after_read;

	modport source (output valid, op, text_byte, query_first, query_second,
	                clear_after_read, input ready);
	modport sink   (input valid, op, text_byte, query_first, query_second,
	                clear_after_read, output ready);
endinterface

interface cbh_out_if import cbh_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUT_WIDTH-1:0] pair_count;
	logic                 over_threshold;

	modport source (output valid, pair_count, over_threshold, input ready);
	modport sink   (input valid, pair_count, over_threshold, output ready);
endinterface

[rtl/core/cbh_ctrl.sv]
// ---------------------------------------------------------------------------
// cbh_ctrl
// Controller: clearing pass after reset, then accept / update per item.
// ---------------------------------------------------------------------------
module cbh_ctrl import cbh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cbh_stat_t stat,
	output cbh_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q, state_nxt;
	logic   stall;

	// A query waits in update until the result register is free
	assign stall = stat.is_query && !stat.out_free;

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		state_nxt    = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = !stall;
				if (!stall) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/core/cbh_dp.sv]
// ---------------------------------------------------------------------------
// cbh_dp
// Datapath: pair count table, pending symbol, item registers, saturating
// increment and the result register.
// ---------------------------------------------------------------------------
module cbh_dp import cbh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cbh_cmd_t                  cmd,
	output cbh_stat_t                 stat,
	input  logic [CFG_DATA_WIDTH-1:0] threshold,
	// item payload
	input  logic                      op,
	input  logic [7:0]                text_byte,
	input  logic [SYM_WIDTH-1:0]      query_first,
	input  logic [SYM_WIDTH-1:0]      query_second,
	input  logic                      clear_after_read,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [OUT_WIDTH-1:0]      pair_count,
	output logic                      over_threshold
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] mem [NUM_PAIRS];
	logic [COUNT_WIDTH-1:0] rdata_q;

	logic [ADDR_WIDTH-1:0] clr_idx_q;
	logic [SYM_WIDTH-1:0]  prev_sym_q;
	logic                  prev_valid_q;

	logic                  op_q;
	logic                  inc_q;
	logic                  range_ok_q;
	logic                  clr_q;
	logic [ADDR_WIDTH-1:0] addr_q;

	logic                  out_valid_q;
	logic [OUT_WIDTH-1:0]  pair_count_q;
	logic                  over_q;

	cbh_sym_t               sym;
	logic                   range_ok;
	logic [ADDR_WIDTH-1:0]  raddr;
	logic                   mem_we;
	logic [ADDR_WIDTH-1:0]  waddr;
	logic [COUNT_WIDTH-1:0] wdata;
	logic [COUNT_WIDTH-1:0] inc_val;
	logic [EXT_WIDTH-1:0]   cnt_ext;
	logic                   cnt_sat;
	logic                   load_out;

	// Decode the incoming item and form the read address
	assign sym      = sym_decode(text_byte);
	assign range_ok = (query_first < SYM_WIDTH'(NUM_SYMBOLS))
	               && (query_second < SYM_WIDTH'(NUM_SYMBOLS));

	always_comb begin
		if (op == OP_QUERY) begin
			raddr = range_ok ? pair_addr(query_first, query_second) : '0;
		end else begin
			raddr = pair_addr(prev_sym_q, sym.sym);
		end
	end

	// Status to controller
	assign stat.clr_last = (clr_idx_q == ADDR_WIDTH'(NUM_PAIRS - 1));
	assign stat.is_query = (op_q == OP_QUERY);
	assign stat.out_free = !out_valid_q || out_ready;

	// Saturating increment and write-back select
	assign inc_val = (rdata_q == COUNT_MAX) ? rdata_q : rdata_q + 1'b1;

	always_comb begin
		mem_we = 1'b0;
		waddr  = addr_q;
		wdata  = '0;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
			waddr  = clr_idx_q;
		end else if (cmd.update) begin
			if (op_q == OP_QUERY) begin
				mem_we = range_ok_q && clr_q;
			end else begin
				mem_we = inc_q;
				wdata  = inc_val;
			end
		end
	end

	// Table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (cmd.accept) rdata_q <= mem[raddr];
	end

	// Clearing pass index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step && !stat.clr_last) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// Pending symbol of the current word; queries leave it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sym_q   <= '0;
			prev_valid_q <= 1'b0;
		end else if (cmd.accept && op == OP_TEXT) begin
			prev_valid_q <= sym.valid;
			if (sym.valid) prev_sym_q <= sym.sym;
		end
	end

	// Item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_TEXT;
		end else if (cmd.accept) begin
			op_q <= op;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			inc_q      <= sym.valid && prev_valid_q;
			range_ok_q <= range_ok;
			clr_q      <= clear_after_read;
			addr_q     <= raddr;
		end
	end

	// Result formatting: saturate to output width, compare on full counter
	assign cnt_ext  = range_ok_q ? EXT_WIDTH'(rdata_q) : '0;
	assign cnt_sat  = |(cnt_ext >> OUT_WIDTH);
	assign load_out = cmd.update && (op_q == OP_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pair_count_q <= cnt_sat ? '1 : cnt_ext[OUT_WIDTH-1:0];
			over_q       <= cnt_ext > EXT_WIDTH'(threshold);
		end
	end

	assign out_valid      = out_valid_q;
	assign pair_count     = pair_count_q;
	assign over_threshold = over_q;

endmodule

[rtl/core/char_bigram_histogram.sv]
// ---------------------------------------------------------------------------
// char_bigram_histogram
// Counts adjacent letter/digit pairs inside words of a byte stream in a
// 36x36 table of saturating counters; queries read and optionally clear one.
// ---------------------------------------------------------------------------
// After reset the block sweeps the 1296-entry count table to zero, one entry
// per cycle, and holds in_ch.ready low for the whole sweep; the threshold
// register can be written meanwhile. Afterwards each item passes an accept
// step, which reads the table entry, and then an update step, which writes the
// incremented or cleared value back through the table's single write port
// and, for a query, loads the result register. A query waits in its update
// step while an earlier result is still held unread.
module char_bigram_histogram import cbh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	cbh_in_if.sink                    in_ch,
	cbh_out_if.source                 out_ch,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	cbh_cmd_t                  cmd;
	cbh_stat_t                 stat;
	logic [CFG_DATA_WIDTH-1:0] threshold_q;
	logic                      cfg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
			threshold_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_THRESHOLD) ? threshold_q : '0;

	cbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cbh_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.threshold        (threshold_q),
		.op               (in_ch.op),
		.text_byte        (in_ch.text_byte),
		.query_first      (in_ch.query_first),
		.query_second     (in_ch.query_second),
		.clear_after_read (in_ch.clear_after_read),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.pair_count       (out_ch.pair_count),
		.over_threshold   (out_ch.over_threshold)
	);

	// No transaction is taken while the table is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> !cmd.clr_step)
		else $error("input transaction accepted during clearing pass");

	// Only one item is in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item accepted while one is in flight");

	// A finished query always presents a result next cycle
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && stat.is_query) |=> out_ch.valid)
		else $error("query finished without a result");

	// After an accepted item the controller neither clears nor accepts again
	a_update_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !cmd.clr_step && !in_ch.ready)
		else $error("controller left update path after accept");

endmodule
